### sv/mie_pkg.sv
// Package for the modular inverse block.
// Holds the default data width and the reset value of the modulus register.
// No dependencies.
`default_nettype none

package mie_pkg;

   // Default operand width in bits.
   localparam int MIE_DATA_WIDTH = 16;

   // Modulus after reset, truncated to the data width where it is used.
   localparam int MIE_MODULUS_RESET = 95;

endpackage : mie_pkg

`default_nettype wire

### sv/mie_step_unit.sv
// Shared arithmetic unit: one bit of a restoring division together with one
// Horner step that builds quotient times coefficient.
// Depends on mie_pkg for the default width.
`default_nettype none

module mie_step_unit
   import mie_pkg::*;
#(
   parameter int DATA_WIDTH = MIE_DATA_WIDTH
) (
   input  wire logic [DATA_WIDTH-1:0]        rem,
   input  wire logic                         dvd_bit,
   input  wire logic [DATA_WIDTH-1:0]        divisor,
   input  wire logic signed [DATA_WIDTH+1:0] prod,
   input  wire logic signed [DATA_WIDTH+1:0] coef,
   output logic      [DATA_WIDTH-1:0]        rem_next,
   output logic                              q_bit,
   output logic signed [DATA_WIDTH+1:0]      prod_next
);

   logic [DATA_WIDTH:0]          trial;
   logic [DATA_WIDTH+1:0]        diff;
   logic signed [DATA_WIDTH+1:0] prod_shl;

   // Shift in the next dividend bit and try to subtract the divisor.
   always_comb begin
      trial    = {rem, dvd_bit};
      diff     = {1'b0, trial} - {2'b00, divisor};
      q_bit    = ~diff[DATA_WIDTH+1];
      rem_next = q_bit ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
   end

   // Accumulate quotient times coefficient, most significant bit first.
   always_comb begin
      prod_shl  = prod <<< 1;
      prod_next = q_bit ? (prod_shl + coef) : prod_shl;
   end

endmodule : mie_step_unit

`default_nettype wire

### sv/mie_seq.sv
// Sequencer of the extended Euclidean algorithm: holds remainders and
// coefficients, drives the shared step unit and registers the result word.
// Depends on mie_pkg and mie_step_unit.
`default_nettype none

module mie_seq
   import mie_pkg::*;
#(
   parameter int DATA_WIDTH = MIE_DATA_WIDTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DATA_WIDTH-1:0] value,
   input  wire logic [DATA_WIDTH-1:0] modulus,
   output logic                       busy,
   output logic                       rsp_valid,
   output logic [DATA_WIDTH-1:0]      rsp_inverse_out,
   output logic                       rsp_invertible
);

   localparam int SW = DATA_WIDTH + 2;
   localparam int CW = $clog2(DATA_WIDTH);
   localparam logic [CW-1:0] CNT_LAST = CW'(DATA_WIDTH - 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_UPD   = 3'd3;
   localparam logic [2:0] ST_FIX1  = 3'd4;
   localparam logic [2:0] ST_FIX2  = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic [DATA_WIDTH-1:0] r0_ff, r0_in, r1_ff, r1_in;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in, dvd_ff, dvd_in;
   logic signed [SW-1:0]  s0_ff, s0_in, s1_ff, s1_in, p_ff, p_in, x_ff, x_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  valid_ff, valid_in;
   logic [DATA_WIDTH-1:0] inv_ff, inv_in;
   logic                  ok_ff, ok_in;

   logic [DATA_WIDTH-1:0] rem_next;
   logic                  q_bit;
   logic signed [SW-1:0]  p_next;
   logic signed [SW-1:0]  mod_ext;

   assign mod_ext = SW'({2'b00, modulus});

   // One division bit per cycle on the current remainder pair.
   mie_step_unit #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_step (
      .rem      (rem_ff),
      .dvd_bit  (dvd_ff[DATA_WIDTH-1]),
      .divisor  (r1_ff),
      .prod     (p_ff),
      .coef     (s1_ff),
      .rem_next (rem_next),
      .q_bit    (q_bit),
      .prod_next(p_next)
   );

   // Next-state and datapath control.
   always_comb begin
      state_in = state_ff;
      r0_in    = r0_ff;
      r1_in    = r1_ff;
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      s0_in    = s0_ff;
      s1_in    = s1_ff;
      p_in     = p_ff;
      x_in     = x_ff;
      cnt_in   = cnt_ff;
      valid_in = 1'b0;
      inv_in   = inv_ff;
      ok_in    = ok_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (modulus == '0) begin
                  // No residue class exists: answer at once.
                  valid_in = 1'b1;
                  inv_in   = '0;
                  ok_in    = 1'b0;
               end else begin
                  r0_in    = value;
                  r1_in    = modulus;
                  s0_in    = SW'(1);
                  s1_in    = '0;
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (r1_ff == '0) begin
               state_in = ST_FIX1;
            end else begin
               rem_in   = '0;
               dvd_in   = r0_ff;
               p_in     = '0;
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = rem_next;
            dvd_in = {dvd_ff[DATA_WIDTH-2:0], 1'b0};
            p_in   = p_next;
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            // Shift the remainder and coefficient pairs by one Euclid step.
            r0_in    = r1_ff;
            r1_in    = rem_ff;
            s0_in    = s1_ff;
            s1_in    = s0_ff - p_ff;
            state_in = ST_CHECK;
         end
         ST_FIX1: begin
            if (r0_ff != DATA_WIDTH'(1)) begin
               valid_in = 1'b1;
               inv_in   = '0;
               ok_in    = 1'b0;
               state_in = ST_IDLE;
            end else begin
               x_in     = s0_ff[SW-1] ? (s0_ff + mod_ext) : s0_ff;
               state_in = ST_FIX2;
            end
         end
         ST_FIX2: begin
            // Fold a coefficient equal to the modulus back to zero.
            valid_in = 1'b1;
            ok_in    = 1'b1;
            if (x_ff >= mod_ext) begin
               inv_in = DATA_WIDTH'(x_ff - mod_ext);
            end else begin
               inv_in = x_ff[DATA_WIDTH-1:0];
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      r0_ff  <= r0_in;
      r1_ff  <= r1_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      s0_ff  <= s0_in;
      s1_ff  <= s1_in;
      p_ff   <= p_in;
      x_ff   <= x_in;
      cnt_ff <= cnt_in;
      inv_ff <= inv_in;
      ok_ff  <= ok_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = valid_ff;
   assign rsp_inverse_out = inv_ff;
   assign rsp_invertible  = ok_ff;

endmodule : mie_seq

`default_nettype wire

### sv/modular_inverse_ext_euclid.sv
// Modular inverse by the extended Euclidean algorithm. A word is taken when
// start is high and busy is low; the result word appears for exactly one
// cycle with rsp_valid high and cannot be stalled, so the receiver must take
// it then. Each Euclid step is one remainder check, bit-serial division in
// the shared step unit and one update. 16-bit operands need at most 23
// steps. A zero modulus answers on the next cycle without raising busy.
// The user must write the modulus through csr_we / csr_wdata only while
// busy is low; the block itself does not enforce this. The modulus resets
// to 95. Depends on mie_pkg and mie_seq.
`default_nettype none

module modular_inverse_ext_euclid
   import mie_pkg::*;
#(
   parameter int DATA_WIDTH = MIE_DATA_WIDTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [DATA_WIDTH-1:0] req_value,
   output logic                       rsp_valid,
   output logic [DATA_WIDTH-1:0]      rsp_inverse_out,
   output logic                       rsp_invertible,
   input  wire logic                  csr_we,
   input  wire logic [DATA_WIDTH-1:0] csr_wdata
);

   localparam logic [DATA_WIDTH-1:0] MODULUS_INIT = DATA_WIDTH'(MIE_MODULUS_RESET);

   logic [DATA_WIDTH-1:0] modulus_ff, modulus_in;

   // Modulus register.
   always_comb begin
      modulus_in = csr_we ? csr_wdata : modulus_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MODULUS_INIT;
      end else begin
         modulus_ff <= modulus_in;
      end
   end

   // Euclid sequencer with its shared step unit.
   mie_seq #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .value          (req_value),
      .modulus        (modulus_ff),
      .busy           (busy),
      .rsp_valid      (rsp_valid),
      .rsp_inverse_out(rsp_inverse_out),
      .rsp_invertible (rsp_invertible)
   );

endmodule : modular_inverse_ext_euclid

`default_nettype wire

### dv/tb_modular_inverse_ext_euclid.sv
// Self-checking testbench for the extended Euclidean modular inverse block.
// Depends on mie_pkg and modular_inverse_ext_euclid, and through it on mie_seq and mie_step_unit.
`timescale 1ns / 100ps

module tb_modular_inverse_ext_euclid;
   import mie_pkg::*;

   localparam int DW = MIE_DATA_WIDTH;

   typedef logic [DW-1:0] word_type;

   // One expected result word.
   typedef struct {
      word_type inverse_out;
      logic     invertible;
   } inverse_word_type;

   // What the driver does next: send a value, rewrite the modulus, or drain.
   typedef enum logic [1:0] {
      STEP_VALUE,
      STEP_SET_MODULUS,
      STEP_DRAIN
   } step_kind_type;

   typedef struct {
      step_kind_type kind;
      word_type      data;
      int unsigned   gap;
      bit            after_done;
   } stim_step_type;

   logic     clock     = 1'b0;
   logic     reset     = 1'b1;
   logic     start     = 1'b0;
   logic     csr_we    = 1'b0;
   word_type req_value = '0;
   word_type csr_wdata = '0;
   logic     busy;
   logic     rsp_valid;
   word_type rsp_inverse_out;
   logic     rsp_invertible;

   stim_step_type    pending_steps[$];
   inverse_word_type expected_inverses[$];
   word_type         modulus_model = word_type'(MIE_MODULUS_RESET);
   int               words_accepted = 0;
   int               words_returned = 0;
   int               error_count = 0;
   int unsigned      hold_cnt = 0;
   bit               idle_enabled = 1'b1;

   modular_inverse_ext_euclid #(
      .DATA_WIDTH(DW)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_inverse_out(rsp_inverse_out),
      .rsp_invertible (rsp_invertible),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata)
   );

   // 12 ns clock.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Extended Euclid on the value and modulus; the Bezout coefficient of the
   // value is folded into 0..m-1 when the gcd is one.
   function automatic inverse_word_type calc_mod_inverse(input word_type a,
                                                         input word_type m);
      longint           r0, r1, s0, s1, q, tmp, mod_l;
      inverse_word_type res;
      res.inverse_out = '0;
      res.invertible  = 1'b0;
      mod_l = longint'(m);
      if (mod_l != 0) begin
         r0 = longint'(a);
         r1 = mod_l;
         s0 = 1;
         s1 = 0;
         while (r1 != 0) begin
            q   = r0 / r1;
            tmp = r0 - q * r1;
            r0  = r1;
            r1  = tmp;
            tmp = s0 - q * s1;
            s0  = s1;
            s1  = tmp;
         end
         if (r0 == 1) begin
            tmp = s0 % mod_l;
            if (tmp < 0) begin
               tmp = tmp + mod_l;
            end
            res.inverse_out = word_type'(tmp);
            res.invertible  = 1'b1;
         end
      end
      return res;
   endfunction

   // Queue one value with a random lead-in gap (none when idling is off),
   // counted either from the previous acceptance or only while the block is idle.
   task automatic add_value(input word_type v);
      stim_step_type s;
      s.kind       = STEP_VALUE;
      s.data       = v;
      s.gap        = idle_enabled ? $urandom_range(0, 16) : 0;
      s.after_done = 1'($urandom_range(0, 1));
      pending_steps.push_back(s);
   endtask

   task automatic set_modulus(input word_type m);
      stim_step_type s;
      s.kind       = STEP_SET_MODULUS;
      s.data       = m;
      s.gap        = 0;
      s.after_done = 1'b0;
      pending_steps.push_back(s);
   endtask

   task automatic add_drain();
      stim_step_type s;
      s.kind       = STEP_DRAIN;
      s.data       = '0;
      s.gap        = 0;
      s.after_done = 1'b0;
      pending_steps.push_back(s);
   endtask

   // Driver: records accepted words, tracks returned words, and launches the
   // next step. Every driven signal gets a single assignment per edge.
   always @(posedge clock) begin : word_driver
      logic nxt_start;
      logic nxt_we;
      if (reset) begin
         start    <= 1'b0;
         csr_we   <= 1'b0;
         hold_cnt <= 0;
      end else begin
         nxt_start = start;
         nxt_we    = 1'b0;
         if (rsp_valid) begin
            words_returned++;
         end
         if (start && !busy) begin
            expected_inverses.push_back(calc_mod_inverse(req_value, modulus_model));
            words_accepted++;
            nxt_start = 1'b0;
         end
         if (!nxt_start && !csr_we && pending_steps.size() != 0) begin
            case (pending_steps[0].kind)
               STEP_VALUE: begin
                  if (hold_cnt < pending_steps[0].gap) begin
                     if (!busy || !pending_steps[0].after_done) begin
                        hold_cnt <= hold_cnt + 1;
                     end
                  end else begin
                     nxt_start = 1'b1;
                     req_value <= pending_steps[0].data;
                     hold_cnt  <= 0;
                     void'(pending_steps.pop_front());
                  end
               end
               STEP_SET_MODULUS: begin
                  // The modulus only changes once the block is idle.
                  if (words_returned >= words_accepted && !busy) begin
                     nxt_we = 1'b1;
                     csr_wdata     <= pending_steps[0].data;
                     modulus_model = pending_steps[0].data;
                     void'(pending_steps.pop_front());
                  end
               end
               STEP_DRAIN: begin
                  if (words_returned >= words_accepted && !busy) begin
                     void'(pending_steps.pop_front());
                  end
               end
               default: begin
                  void'(pending_steps.pop_front());
               end
            endcase
         end
         start  <= nxt_start;
         csr_we <= nxt_we;
      end
   end

   // Checker: every result word is compared with the oldest expectation.
   always @(posedge clock) begin : result_checker
      inverse_word_type exp_word;
      if (!reset && rsp_valid) begin
         if (expected_inverses.size() == 0) begin
            $error("unexpected result word: inverse_out %0d, invertible %0b",
                   rsp_inverse_out, rsp_invertible);
            error_count++;
         end else begin
            exp_word = expected_inverses.pop_front();
            if (rsp_inverse_out !== exp_word.inverse_out) begin
               $error("inverse_out mismatch: expected %0d, actual %0d",
                      exp_word.inverse_out, rsp_inverse_out);
               error_count++;
            end
            if (rsp_invertible !== exp_word.invertible) begin
               $error("invertible mismatch: expected %0b, actual %0b",
                      exp_word.invertible, rsp_invertible);
               error_count++;
            end
         end
      end
   end

   // Stimulus and end of run.
   initial begin : stimulus
      word_type m;
      word_type v;
      int       f;
      // Reset modulus: zero, one, around the modulus, top of range, shared factor.
      add_value(16'd0);
      add_value(16'd1);
      add_value(16'd94);
      add_value(16'd95);
      add_value(16'd96);
      add_value(16'hFFFF);
      add_value(16'd2);
      add_value(16'd5);
      // Largest modulus.
      set_modulus(16'hFFFF);
      add_value(16'd0);
      add_value(16'd1);
      add_value(16'hFFFF);
      add_value(16'hFFFE);
      add_value(16'd3);
      // Modulus one makes everything invertible with inverse zero.
      set_modulus(16'd1);
      add_value(16'd0);
      add_value(16'd12345);
      // Modulus zero has no inverses at all.
      set_modulus(16'd0);
      add_value(16'd7);
      add_value(16'd0);
      // Smallest regular modulus.
      set_modulus(16'd2);
      add_value(16'd1);
      add_value(16'd2);
      add_value(16'hFFFF);
      // Consecutive Fibonacci numbers give the longest Euclid chain.
      set_modulus(16'd46368);
      add_value(16'd28657);

      // Random phases, each with its own modulus and idling style.
      for (int ph = 0; ph < 12; ph++) begin
         case ($urandom_range(0, 7))
            0, 7: m = word_type'($urandom_range(2, 65535));
            1: m = word_type'($urandom_range(2, 255));
            2: m = 16'd65521;
            3: m = word_type'(1 << $urandom_range(1, 15));
            4: m = 16'd95;
            5: m = word_type'($urandom_range(0, 1));
            default: m = 16'hFFFF;
         endcase
         set_modulus(m);
         idle_enabled = ($urandom_range(0, 3) != 0);
         for (int i = 0; i < 50; i++) begin
            case ($urandom_range(0, 5))
               0: v = word_type'($urandom_range(0, 65535));
               1: v = (m > 1) ? word_type'($urandom_range(0, m - 1)) : word_type'($urandom);
               2: begin
                  case ($urandom_range(0, 5))
                     0: v = '0;
                     1: v = 16'd1;
                     2: v = m - 1'b1;
                     3: v = m;
                     4: v = m + 1'b1;
                     default: v = 16'hFFFF;
                  endcase
               end
               3: begin
                  f = $urandom_range(2, 15);
                  v = word_type'(($urandom_range(0, 65535) / f) * f);
               end
               default: v = word_type'($urandom_range(0, 255));
            endcase
            add_value(v);
            // Let the pipeline empty once in the middle of a phase.
            if (ph == 6 && i == 25) begin
               add_drain();
            end
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Look just after each edge, once the driver's updates have settled.
      do begin
         @(posedge clock);
         #1;
      end while (pending_steps.size() != 0 || start || words_returned < words_accepted);
      repeat (50) @(posedge clock);

      if (expected_inverses.size() != 0) begin
         $error("%0d expected result words never arrived", expected_inverses.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Hang guard, several times the slowest legal run.
   initial begin : watchdog
      #20_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

### modular_inverse_ext_euclid.f
sv/mie_pkg.sv
sv/mie_step_unit.sv
sv/mie_seq.sv
sv/modular_inverse_ext_euclid.sv
dv/tb_modular_inverse_ext_euclid.sv
